// ===== rtl/pnf_pkg.sv =====
// shared types, character codes and helpers for the padded number formatter
package pnf_pkg;

  // conversion selector codes
  localparam logic OP_DEC = 1'b0;
  localparam logic OP_HEX = 1'b1;

  // sizes
  localparam int VALUE_W    = 32;
  localparam int DEC_DIGITS = 10;
  localparam int CONV_STEPS = 32;
  localparam int POS_W      = 6;

  // precision saturates here so the field never exceeds 63 characters
  localparam logic [POS_W-1:0] MAX_PREC = 6'd62;

  // ascii codes
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_MINUS = 8'h2d;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_ALPHA = 8'h57;  // 'a' minus ten

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic shift;
    logic measure;
    logic emit;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic last;
  } sts_t;

  // one digit value to its lower-case ascii character
  function automatic logic [7:0] digit_char(input logic [3:0] d);
    logic [7:0] c;
    if (d < 4'd10) begin
      c = CHAR_ZERO + {4'b0, d};
    end else begin
      c = CHAR_ALPHA + {4'b0, d};
    end
    return c;
  endfunction

endpackage

// ===== rtl/pnf_ctrl.sv =====
// controller state machine: conversion steps, field measure and character emission
module pnf_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic           op,
  input  pnf_pkg::sts_t  sts,
  output pnf_pkg::cmd_t  cmd,
  output logic           busy
);
  import pnf_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CONV = 2'd1;
  localparam logic [1:0] ST_MEAS = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  localparam logic [4:0] LAST_STEP = 5'(CONV_STEPS - 1);

  logic [1:0] state_r, state_nxt;
  logic [4:0] cnt_r, cnt_nxt;

  // next state and step counter
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      ST_IDLE: begin
        cnt_nxt = 5'd0;
        if (start) begin
          state_nxt = (op == OP_HEX) ? ST_MEAS : ST_CONV;
        end
      end
      ST_CONV: begin
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == LAST_STEP) begin
          state_nxt = ST_MEAS;
        end
      end
      ST_MEAS: begin
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts.last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= 5'd0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // commands
  always_comb begin
    cmd.load    = start && (state_r == ST_IDLE);
    cmd.shift   = (state_r == ST_CONV);
    cmd.measure = (state_r == ST_MEAS);
    cmd.emit    = (state_r == ST_EMIT);
  end

  assign busy = (state_r != ST_IDLE);

endmodule

// ===== rtl/pnf_dpath.sv =====
// datapath: magnitude, binary to bcd shifter, field lengths and character select
module pnf_dpath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  pnf_pkg::cmd_t                 cmd,
  input  logic                          in_operation,
  input  logic [pnf_pkg::VALUE_W-1:0]   in_value,
  input  logic [pnf_pkg::POS_W-1:0]     in_field_width,
  input  logic [pnf_pkg::POS_W-1:0]     in_min_digits,
  output pnf_pkg::sts_t                 sts,
  output logic                          out_strobe,
  output logic [7:0]                    out_char,
  output logic [pnf_pkg::POS_W-1:0]     out_char_index,
  output logic                          out_is_last
);
  import pnf_pkg::*;

  localparam int BCD_W = 4 * DEC_DIGITS;

  logic                 neg_r;
  logic [VALUE_W-1:0]   bin_r, bin_nxt;
  logic [BCD_W-1:0]     bcd_r, bcd_nxt, bcd_adj;
  logic [POS_W-1:0]     width_r, prec_r;
  logic [POS_W-1:0]     spaces_r, digstart_r, total_r, pos_r;
  logic                 out_strobe_r;
  logic [7:0]           out_char_r;
  logic [POS_W-1:0]     out_index_r;
  logic                 out_last_r;

  logic                 in_neg;
  logic [VALUE_W-1:0]   in_mag;
  logic [3:0]           ndig;
  logic [POS_W-1:0]     prec_sat, zeros, body, spaces, digstart, total;
  logic [POS_W-1:0]     last_pos, didx_full;
  logic [3:0]           didx, dig;
  logic [7:0]           ch;

  // sign and magnitude of the incoming value
  assign in_neg = (in_operation == OP_DEC) && in_value[VALUE_W-1];
  assign in_mag = in_neg ? (~in_value + 1'b1) : in_value;

  // one double-dabble step: add 3 to every digit at 5 or above, then shift
  always_comb begin
    for (int i = 0; i < DEC_DIGITS; i++) begin
      if (bcd_r[i*4 +: 4] >= 4'd5) begin
        bcd_adj[i*4 +: 4] = bcd_r[i*4 +: 4] + 4'd3;
      end else begin
        bcd_adj[i*4 +: 4] = bcd_r[i*4 +: 4];
      end
    end
    bcd_nxt = {bcd_adj[BCD_W-2:0], bin_r[VALUE_W-1]};
    bin_nxt = {bin_r[VALUE_W-2:0], 1'b0};
  end

  // digit count: highest nonzero digit, at least one
  always_comb begin
    ndig = 4'd1;
    for (int i = 0; i < DEC_DIGITS; i++) begin
      if (bcd_r[i*4 +: 4] != 4'd0) begin
        ndig = 4'(i + 1);
      end
    end
  end

  // field lengths
  always_comb begin
    prec_sat = (prec_r > MAX_PREC) ? MAX_PREC : prec_r;
    zeros    = (prec_sat > {2'b0, ndig}) ? (prec_sat - {2'b0, ndig}) : '0;
    body     = {{(POS_W-1){1'b0}}, neg_r} + zeros + {2'b0, ndig};
    spaces   = (width_r > body) ? (width_r - body) : '0;
    digstart = spaces + {{(POS_W-1){1'b0}}, neg_r} + zeros;
    total    = spaces + body;
  end

  // operand and conversion registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      neg_r   <= in_neg;
      width_r <= in_field_width;
      prec_r  <= in_min_digits;
      bin_r   <= in_mag;
      if (in_operation == OP_HEX) begin
        bcd_r <= {{(BCD_W-VALUE_W){1'b0}}, in_value};
      end else begin
        bcd_r <= '0;
      end
    end else if (cmd.shift) begin
      bin_r <= bin_nxt;
      bcd_r <= bcd_nxt;
    end
  end

  // field layout and position counter
  always_ff @(posedge clk) begin
    if (cmd.measure) begin
      spaces_r   <= spaces;
      digstart_r <= digstart;
      total_r    <= total;
      pos_r      <= '0;
    end else if (cmd.emit) begin
      pos_r <= pos_r + 1'b1;
    end
  end

  // character at the current position
  assign last_pos  = total_r - 1'b1;
  assign didx_full = last_pos - pos_r;
  assign didx      = didx_full[3:0];

  always_comb begin
    case (didx)
      4'd0:    dig = bcd_r[3:0];
      4'd1:    dig = bcd_r[7:4];
      4'd2:    dig = bcd_r[11:8];
      4'd3:    dig = bcd_r[15:12];
      4'd4:    dig = bcd_r[19:16];
      4'd5:    dig = bcd_r[23:20];
      4'd6:    dig = bcd_r[27:24];
      4'd7:    dig = bcd_r[31:28];
      4'd8:    dig = bcd_r[35:32];
      4'd9:    dig = bcd_r[39:36];
      default: dig = 4'd0;
    endcase
  end

  always_comb begin
    if (pos_r < spaces_r) begin
      ch = CHAR_SPACE;
    end else if (neg_r && (pos_r == spaces_r)) begin
      ch = CHAR_MINUS;
    end else if (pos_r < digstart_r) begin
      ch = CHAR_ZERO;
    end else begin
      ch = digit_char(dig);
    end
  end

  assign sts.last = (pos_r == last_pos);

  // output strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= cmd.emit;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_char_r  <= ch;
      out_index_r <= pos_r;
      out_last_r  <= sts.last;
    end
  end

  assign out_strobe     = out_strobe_r;
  assign out_char       = out_char_r;
  assign out_char_index = out_index_r;
  assign out_is_last    = out_last_r;

endmodule

// ===== rtl/padded_number_formatter.sv =====
// Top level of the padded number formatter: controller plus datapath.
// Decimal: binary-to-bcd shift conversion, one measure step, then one character per cycle;
//   a new item is taken only while idle, after the last character of the previous one.
// Hex: no conversion; the load goes straight to the measure step; a field holds at most 63 characters.
// The bcd shifter is the extra work of decimal mode; the single output port sets the per-character rate.
// Synchronous active-low reset returns to idle with no strobe; the receiver cannot stall.
module padded_number_formatter (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_operation,
  input  logic [pnf_pkg::VALUE_W-1:0]   in_value,
  input  logic [pnf_pkg::POS_W-1:0]     in_field_width,
  input  logic [pnf_pkg::POS_W-1:0]     in_min_digits,
  output logic                          out_strobe,
  output logic [7:0]                    out_char,
  output logic [pnf_pkg::POS_W-1:0]     out_char_index,
  output logic                          out_is_last
);
  import pnf_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequencing
  pnf_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .op    (in_operation),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  // conversion and character generation
  pnf_dpath u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .in_operation   (in_operation),
    .in_value       (in_value),
    .in_field_width (in_field_width),
    .in_min_digits  (in_min_digits),
    .sts            (sts),
    .out_strobe     (out_strobe),
    .out_char       (out_char),
    .out_char_index (out_char_index),
    .out_is_last    (out_is_last)
  );

endmodule

// ===== rtl/pnf_checker.sv =====
// port-level checks for the padded number formatter, bound to the top level
module pnf_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          start,
  input logic                          busy,
  input logic                          out_strobe,
  input logic [pnf_pkg::POS_W-1:0]     out_char_index,
  input logic                          out_is_last
);
  import pnf_pkg::*;

  // an accepted item makes the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted item did not raise busy");

  // characters of one item come on consecutive cycles
  a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_is_last |=> out_strobe)
    else $error("gap inside a field");

  // positions count up by one
  a_index_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_is_last |=> out_char_index == POS_W'($past(out_char_index) + 1'b1))
    else $error("character index did not step by one");

  // busy while a field is still going out, free on its last character
  a_busy_mid: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_is_last |-> busy)
    else $error("idle in the middle of a field");

  a_free_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_is_last |-> !busy)
    else $error("still busy on the last character");

endmodule

bind padded_number_formatter pnf_checker u_pnf_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .out_strobe     (out_strobe),
  .out_char_index (out_char_index),
  .out_is_last    (out_is_last)
);
